/* rtl/core/mrop_pkg.sv */
package mrop_pkg;

  // size limits of the rectangle
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // fixed field widths
  localparam int CFG_W   = 11;
  localparam int CIDX_W  = 3;
  localparam int OP_W    = 3;
  localparam int OFS_W   = 3;
  localparam int BYTE_W  = 8;

  // derived widths
  localparam int SPAN_W  = $clog2(MAX_WIDTH + 15);
  localparam int WCMP_W  = (SPAN_W > CFG_W) ? SPAN_W : CFG_W;
  localparam int COL_W   = $clog2((MAX_WIDTH + 14) / 8);
  localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HCMP_W  = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

  typedef enum logic [OP_W-1:0] {
    OP_COPY   = 3'd0,
    OP_XOR    = 3'd1,
    OP_MASKED = 3'd2,
    OP_FILL   = 3'd3,
    OP_INVERT = 3'd4
  } op_mode_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_OP_MODE     = 3'd0,
    REG_LEFT_OFFSET = 3'd1,
    REG_WIDTH       = 3'd2,
    REG_ROWS        = 3'd3,
    REG_FILL_COLOR  = 3'd4
  } cfg_index_t;

  // one request after edge masking, waiting for the logic op
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] dest_byte;
    logic [BYTE_W-1:0] src_byte;
    logic [BYTE_W-1:0] mask_byte;
    logic [BYTE_W-1:0] edge_mask;
    logic              row_end;
    logic              rect_end;
  } stage_t;

endpackage

/* rtl/core/mrop_in_if.sv */
interface mrop_in_if
  import mrop_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] dest_byte;
  logic [BYTE_W-1:0] src_byte;
  logic [BYTE_W-1:0] mask_byte;

  modport source (output valid, dest_byte, src_byte, mask_byte, input ready);
  modport sink   (input valid, dest_byte, src_byte, mask_byte, output ready);
endinterface

/* rtl/core/mrop_out_if.sv */
interface mrop_out_if
  import mrop_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] result_byte;
  logic              row_end;
  logic              rect_end;

  modport source (output valid, result_byte, row_end, rect_end, input ready);
  modport sink   (input valid, result_byte, row_end, rect_end, output ready);
endinterface

/* rtl/core/mono_raster_op_engine.sv */
// an accepted input request is registered in stage 1, and its result in stage 2, which drives out_chan
// throughput: one byte per cycle, limited only by out_chan back-pressure
// stage 1 holds the edge mask and counters' verdict, stage 2 the op result
// rst_n is synchronous and active low: counters go to 0, pipeline empties,
// registers return to copy mode, offset 0, width 8, one row, fill colour 0
module mono_raster_op_engine
  import mrop_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  mrop_in_if.sink            in_chan,
  mrop_out_if.source         out_chan,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  // configuration registers
  logic [OP_W-1:0]   op_mode_r;
  logic [OFS_W-1:0]  left_offset_r;
  logic [CFG_W-1:0]  width_pixels_r;
  logic [CFG_W-1:0]  row_count_r;
  logic              fill_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r      <= OP_COPY;
      left_offset_r  <= '0;
      width_pixels_r <= CFG_W'(8);
      row_count_r    <= CFG_W'(1);
      fill_color_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_OP_MODE:     op_mode_r      <= cfg_wdata[OP_W-1:0];
        REG_LEFT_OFFSET: left_offset_r  <= cfg_wdata[OFS_W-1:0];
        REG_WIDTH:       width_pixels_r <= cfg_wdata;
        REG_ROWS:        row_count_r    <= cfg_wdata;
        REG_FILL_COLOR:  fill_color_r   <= cfg_wdata[0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // rectangle geometry, straight from the registers
  logic [WCMP_W-1:0] w_ext;
  logic [SPAN_W-1:0] eff_width;
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] span_up;
  logic [SPAN_W-1:0] last_col;
  logic [2:0]        end_bits;
  logic [HCMP_W-1:0] h_ext;
  logic [HCMP_W-1:0] eff_rows;
  logic [ROW_W-1:0]  last_row;

  always_comb begin
    // zero width acts as one pixel, oversize is clamped
    w_ext = WCMP_W'(width_pixels_r);
    if (w_ext == '0)
      eff_width = SPAN_W'(1);
    else if (w_ext > WCMP_W'(MAX_WIDTH))
      eff_width = SPAN_W'(MAX_WIDTH);
    else
      eff_width = w_ext[SPAN_W-1:0];
    span     = SPAN_W'(left_offset_r) + eff_width;
    span_up  = span + SPAN_W'(7);
    last_col = (span_up >> 3) - SPAN_W'(1);
    end_bits = span[2:0];

    // same treatment for the row count
    h_ext = HCMP_W'(row_count_r);
    if (h_ext == '0)
      eff_rows = HCMP_W'(1);
    else if (h_ext > HCMP_W'(MAX_HEIGHT))
      eff_rows = HCMP_W'(MAX_HEIGHT);
    else
      eff_rows = h_ext;
    last_row = ROW_W'(eff_rows - HCMP_W'(1));
  end

  // pipeline handshake: each stage loads when it is empty or drains
  stage_t            s1_r;
  stage_t            s1_nxt;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_result_r;
  logic              out_row_end_r;
  logic              out_rect_end_r;
  logic              s2_load;
  logic              in_acc;

  assign s2_load       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_r.valid || s2_load;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // position counters, moved only by accepted requests
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  logic             at_row_end;
  logic             at_rect_end;
  logic [BYTE_W-1:0] edge_mask;

  always_comb begin
    // a column at or past the last byte counts as the last byte
    at_row_end  = SPAN_W'(col_r) >= last_col;
    at_rect_end = at_row_end && (row_r >= last_row);

    edge_mask = '1;
    if (col_r == '0)
      edge_mask = edge_mask & (8'hff >> left_offset_r);
    if (at_row_end && (end_bits != 3'd0))
      edge_mask = edge_mask & ~(8'hff >> end_bits);

    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (at_row_end) begin
        col_nxt = '0;
        row_nxt = at_rect_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end

    s1_nxt = s1_r;
    if (in_chan.ready) begin
      s1_nxt.valid     = in_chan.valid;
      s1_nxt.dest_byte = in_chan.dest_byte;
      s1_nxt.src_byte  = in_chan.src_byte;
      s1_nxt.mask_byte = in_chan.mask_byte;
      s1_nxt.edge_mask = edge_mask;
      s1_nxt.row_end   = at_row_end;
      s1_nxt.rect_end  = at_rect_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      s1_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      s1_r  <= s1_nxt;
    end
  end

  // raster op inside the edge mask
  logic [BYTE_W-1:0] colour;
  logic [BYTE_W-1:0] result_nxt;

  always_comb begin
    colour = {BYTE_W{fill_color_r}};
    unique case (op_mode_t'(op_mode_r))
      OP_COPY:   result_nxt = s1_r.dest_byte ^ ((s1_r.dest_byte ^ s1_r.src_byte)
                              & s1_r.edge_mask);
      OP_XOR:    result_nxt = s1_r.dest_byte ^ (s1_r.src_byte & s1_r.edge_mask);
      OP_MASKED: result_nxt = s1_r.dest_byte ^ ((s1_r.dest_byte ^ s1_r.src_byte)
                              & s1_r.edge_mask & s1_r.mask_byte);
      OP_FILL:   result_nxt = s1_r.dest_byte ^ ((s1_r.dest_byte ^ colour)
                              & s1_r.edge_mask);
      OP_INVERT: result_nxt = s1_r.dest_byte ^ s1_r.edge_mask;
      default:   result_nxt = s1_r.dest_byte;  // unused codes leave the byte alone
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= s1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_result_r   <= result_nxt;
      out_row_end_r  <= s1_r.row_end;
      out_rect_end_r <= s1_r.rect_end;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_byte = out_result_r;
  assign out_chan.row_end     = out_row_end_r;
  assign out_chan.rect_end    = out_rect_end_r;

endmodule

/* rtl/core/mrop_checker.sv */
module mrop_checker
  import mrop_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_result_byte,
  input logic              out_row_end,
  input logic              out_rect_end
);

  // pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // the last byte of a rectangle always closes a row
  a_rect_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rect_end) |-> out_row_end)
    else $error("rectangle end without row end");

  // a free output side never blocks the input side
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output drains");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result_byte)
      && $stable(out_row_end) && $stable(out_rect_end)))
    else $error("stalled result changed");

endmodule

bind mono_raster_op_engine mrop_checker u_mrop_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_result_byte (out_chan.result_byte),
  .out_row_end     (out_chan.row_end),
  .out_rect_end    (out_chan.rect_end)
);
